// ----- design/ctks_pkg.sv -----
package ctks_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 255;

    // output queue of per-byte result records
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [5:0] {
        KIND_COMMENT  = 6'd0,
        KIND_IDENT    = 6'd1,
        KIND_LITERAL  = 6'd2,
        KIND_ERROR    = 6'd3,
        KIND_EOF      = 6'd4,
        KIND_SEMI     = 6'd5,
        KIND_LBRACE   = 6'd6,
        KIND_RBRACE   = 6'd7,
        KIND_LPAREN   = 6'd8,
        KIND_RPAREN   = 6'd9,
        KIND_COMMA    = 6'd10,
        KIND_PLUS     = 6'd11,
        KIND_MINUS    = 6'd12,
        KIND_STAR     = 6'd13,
        KIND_SLASH    = 6'd14,
        KIND_TILDE    = 6'd15,
        KIND_PERCENT  = 6'd16,
        KIND_CARET    = 6'd17,
        KIND_QUEST    = 6'd18,
        KIND_COLON    = 6'd19,
        KIND_AMP      = 6'd20,
        KIND_AND_AND  = 6'd21,
        KIND_BAR      = 6'd22,
        KIND_OR_OR    = 6'd23,
        KIND_BANG     = 6'd24,
        KIND_NE       = 6'd25,
        KIND_ASSIGN   = 6'd26,
        KIND_EQ_EQ    = 6'd27,
        KIND_GT       = 6'd28,
        KIND_GE       = 6'd29,
        KIND_SHR      = 6'd30,
        KIND_LT       = 6'd31,
        KIND_LE       = 6'd32,
        KIND_SHL      = 6'd33
    } tok_kind_e;

    typedef struct packed {
        tok_kind_e  kind;
        logic [7:0] len;
    } tok_t;

    // tokens caused by one byte; cnt is 0, 1 or 2
    typedef struct packed {
        logic [1:0] cnt;
        tok_t       tok0;
        tok_t       tok1;
    } rec_t;

endpackage

// ----- design/c_like_token_scanner.sv -----
// channel   dir  tdata                                   tlast        tuser
// s_axis    in   [7:0] data_byte                         line_end     -
// m_axis    out  [5:0] token_kind, [13:6] token_length   last_of_run  -
//
// One source byte per cycle is accepted while the result queue has room.
// A byte yields zero, one or two tokens; the output stage sends one token per
// cycle while m_axis_tready is high, so a run of two-token bytes is limited by
// that single output port. Tokens pass the result queue, then the output register.
// Reset (aresetn low at a clock edge) clears scanner state, queue and output.
// Stalls on m_axis fill the four-record queue, then drop s_axis_tready.
module c_like_token_scanner #(
    parameter int MAX_TOKEN_LEN = ctks_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] token_kind, [13:6] token_length
    output logic        m_axis_tlast
);
    import ctks_pkg::*;

    logic           accept;
    rec_t           rec;
    rec_t           head;
    logic           head_valid;
    logic           full;
    logic           pop;
    logic [QAW:0]   level;
    tok_t           out_tok;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ctks_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_axis_tdata),
        .line_end  (s_axis_tlast),
        .rec       (rec)
    );

    ctks_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && (rec.cnt != 2'd0)),
        .wr_rec    (rec),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (full),
        .level     (level)
    );

    ctks_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_tok      (out_tok),
        .m_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_tok.len, out_tok.kind};

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_eof_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[5:0] == KIND_EOF) |-> m_axis_tdata[13:6] == 8'd1)
        else $error("eof token with wrong length");

    a_op_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[5:0] >= KIND_SEMI)
        |-> (m_axis_tdata[13:6] == 8'd1) || (m_axis_tdata[13:6] == 8'd2))
        else $error("operator token with wrong length");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[15:14] == 2'b00 && m_axis_tdata[5:0] <= KIND_SHL)
        else $error("token kind out of range");

endmodule

// ----- design/ctks_front.sv -----
module ctks_front #(
    parameter int MAX_TOKEN_LEN = ctks_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            line_end,
    output ctks_pkg::rec_t  rec
);
    import ctks_pkg::*;

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    typedef enum logic [2:0] {
        PEND_NONE, PEND_AND, PEND_OR, PEND_NOT, PEND_EQ, PEND_GT, PEND_LT
    } pend_e;

    typedef enum logic [1:0] {
        CLS_NONE, CLS_IDENT, CLS_LIT, CLS_OTHER
    } cls_e;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_EOF  = 8'hFF;

    pend_e         pend_reg, pend_next;
    logic [LW-1:0] wlen_reg, wlen_next;
    cls_e          cls_reg, cls_next;
    logic          bad_reg, bad_next;
    logic          lstart_reg, lstart_next;
    logic          cmnt_reg, cmnt_next;
    logic          skip_reg, skip_next;

    function automatic logic [7:0] sat8(logic [LW-1:0] v);
        logic [16:0] e;
        e = 17'(v);
        return (e > 17'd255) ? 8'hFF : e[7:0];
    endfunction

    function automatic logic [LW-1:0] count_up(logic [LW-1:0] v);
        return (v < LW'(MAX_TOKEN_LEN)) ? v + LW'(1) : v;
    endfunction

    function automatic rec_t push_tok(rec_t r, tok_kind_e k, logic [7:0] l);
        rec_t o;
        o = r;
        if (r.cnt == 2'd0) begin
            o.tok0.kind = k;
            o.tok0.len  = l;
            o.cnt       = 2'd1;
        end else if (r.cnt == 2'd1) begin
            o.tok1.kind = k;
            o.tok1.len  = l;
            o.cnt       = 2'd2;
        end
        return o;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic pend_e pair_code(logic [7:0] b);
        case (b)
            "&":     return PEND_AND;
            "|":     return PEND_OR;
            "!":     return PEND_NOT;
            "=":     return PEND_EQ;
            ">":     return PEND_GT;
            "<":     return PEND_LT;
            default: return PEND_NONE;
        endcase
    endfunction

    function automatic tok_kind_e single_kind(pend_e p);
        case (p)
            PEND_AND: return KIND_AMP;
            PEND_OR:  return KIND_BAR;
            PEND_NOT: return KIND_BANG;
            PEND_EQ:  return KIND_ASSIGN;
            PEND_GT:  return KIND_GT;
            default:  return KIND_LT;
        endcase
    endfunction

    // KIND_COMMENT means the byte does not complete the pair
    function automatic tok_kind_e paired_kind(pend_e p, logic [7:0] b);
        case (p)
            PEND_AND: return (b == "&") ? KIND_AND_AND : KIND_COMMENT;
            PEND_OR:  return (b == "|") ? KIND_OR_OR : KIND_COMMENT;
            PEND_NOT: return (b == "=") ? KIND_NE : KIND_COMMENT;
            PEND_EQ:  return (b == "=") ? KIND_EQ_EQ : KIND_COMMENT;
            PEND_GT:  return (b == "=") ? KIND_GE : ((b == ">") ? KIND_SHR : KIND_COMMENT);
            PEND_LT:  return (b == "=") ? KIND_LE : ((b == "<") ? KIND_SHL : KIND_COMMENT);
            default:  return KIND_COMMENT;
        endcase
    endfunction

    // KIND_COMMENT means not a plain operator
    function automatic tok_kind_e plain_kind(logic [7:0] b);
        case (b)
            ";":     return KIND_SEMI;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            ",":     return KIND_COMMA;
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            "~":     return KIND_TILDE;
            "%":     return KIND_PERCENT;
            "^":     return KIND_CARET;
            "?":     return KIND_QUEST;
            ":":     return KIND_COLON;
            default: return KIND_COMMENT;
        endcase
    endfunction

    function automatic rec_t flush_rec(rec_t r, logic [LW-1:0] wl, cls_e c, logic bad);
        tok_kind_e k;
        if (wl == '0) begin
            return r;
        end
        if (c == CLS_IDENT) begin
            k = KIND_IDENT;
        end else if (c == CLS_LIT && !bad) begin
            k = KIND_LITERAL;
        end else begin
            k = KIND_ERROR;
        end
        return push_tok(r, k, sat8(wl));
    endfunction

    always_comb begin
        logic          consumed;
        logic [LW-1:0] wl_cnt;
        tok_kind_e     pk;
        tok_kind_e     ok;
        pend_e         pc;

        rec         = '0;
        pend_next   = pend_reg;
        wlen_next   = wlen_reg;
        cls_next    = cls_reg;
        bad_next    = bad_reg;
        lstart_next = lstart_reg;
        cmnt_next   = cmnt_reg;
        skip_next   = skip_reg;
        consumed    = 1'b0;
        wl_cnt      = count_up(wlen_reg);
        pk          = paired_kind(pend_reg, data_byte);
        ok          = plain_kind(data_byte);
        pc          = pair_code(data_byte);

        if (skip_reg) begin
            if (line_end) begin
                skip_next   = 1'b0;
                lstart_next = 1'b1;
            end
        end else if (cmnt_reg) begin
            if (line_end) begin
                rec         = push_tok(rec, KIND_COMMENT, sat8(wl_cnt));
                wlen_next   = '0;
                cls_next    = CLS_NONE;
                bad_next    = 1'b0;
                cmnt_next   = 1'b0;
                lstart_next = 1'b1;
            end else begin
                wlen_next = wl_cnt;
            end
        end else if (lstart_reg && data_byte == CH_HASH) begin
            if (line_end) begin
                rec = push_tok(rec, KIND_COMMENT, 8'd0);
            end else begin
                cmnt_next   = 1'b1;
                wlen_next   = '0;
                cls_next    = CLS_NONE;
                bad_next    = 1'b0;
                lstart_next = 1'b0;
            end
        end else begin
            lstart_next = 1'b0;
            if (pend_reg != PEND_NONE) begin
                if (pk != KIND_COMMENT) begin
                    rec      = push_tok(rec, pk, 8'd2);
                    consumed = 1'b1;
                end else begin
                    rec = push_tok(rec, single_kind(pend_reg), 8'd1);
                end
                pend_next = PEND_NONE;
            end

            if (!consumed) begin
                if (data_byte == CH_EOF) begin
                    rec       = flush_rec(rec, wlen_next, cls_next, bad_next);
                    wlen_next = '0;
                    cls_next  = CLS_NONE;
                    bad_next  = 1'b0;
                    rec       = push_tok(rec, KIND_EOF, 8'd1);
                    if (!line_end) begin
                        skip_next = 1'b1;
                    end
                end else if (data_byte == " " || data_byte == 8'h0A ||
                             data_byte == 8'h09 || data_byte == 8'h00) begin
                    rec       = flush_rec(rec, wlen_next, cls_next, bad_next);
                    wlen_next = '0;
                    cls_next  = CLS_NONE;
                    bad_next  = 1'b0;
                end else if (pc != PEND_NONE) begin
                    rec       = flush_rec(rec, wlen_next, cls_next, bad_next);
                    wlen_next = '0;
                    cls_next  = CLS_NONE;
                    bad_next  = 1'b0;
                    pend_next = pc;
                end else if (ok != KIND_COMMENT) begin
                    rec       = flush_rec(rec, wlen_next, cls_next, bad_next);
                    wlen_next = '0;
                    cls_next  = CLS_NONE;
                    bad_next  = 1'b0;
                    rec       = push_tok(rec, ok, 8'd1);
                end else begin
                    // word character; class is fixed by the first one
                    if (wlen_next == '0) begin
                        cls_next = is_letter(data_byte) ? CLS_IDENT :
                                   (is_digit(data_byte) ? CLS_LIT : CLS_OTHER);
                        bad_next = 1'b0;
                    end else if (!is_digit(data_byte) && data_byte != CH_DOT) begin
                        bad_next = 1'b1;
                    end
                    wlen_next = count_up(wlen_next);
                end
            end

            if (line_end) begin
                rec       = flush_rec(rec, wlen_next, cls_next, bad_next);
                wlen_next = '0;
                cls_next  = CLS_NONE;
                bad_next  = 1'b0;
                if (pend_next != PEND_NONE) begin
                    rec       = push_tok(rec, single_kind(pend_next), 8'd1);
                    pend_next = PEND_NONE;
                end
                lstart_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= PEND_NONE;
            wlen_reg   <= '0;
            cls_reg    <= CLS_NONE;
            bad_reg    <= 1'b0;
            lstart_reg <= 1'b1;
            cmnt_reg   <= 1'b0;
            skip_reg   <= 1'b0;
        end else if (accept) begin
            pend_reg   <= pend_next;
            wlen_reg   <= wlen_next;
            cls_reg    <= cls_next;
            bad_reg    <= bad_next;
            lstart_reg <= lstart_next;
            cmnt_reg   <= cmnt_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

// ----- design/ctks_fifo.sv -----
module ctks_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ctks_pkg::rec_t     wr_rec,
    input  logic               pop,
    output ctks_pkg::rec_t     head,
    output logic               not_empty,
    output logic               full,
    output logic [ctks_pkg::QAW:0] level
);
    import ctks_pkg::*;

    rec_t           mem [QDEPTH];
    logic [QAW-1:0] wptr_reg;
    logic [QAW-1:0] rptr_reg;
    logic [QAW:0]   cnt_reg;

    assign head      = mem[rptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (QAW+1)'(QDEPTH));
    assign level     = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + QAW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + QAW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + (QAW+1)'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - (QAW+1)'(1);
            end
        end
    end

endmodule

// ----- design/ctks_back.sv -----
module ctks_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  ctks_pkg::rec_t  head,
    input  logic            head_valid,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output ctks_pkg::tok_t  m_tok,
    output logic            m_last
);
    import ctks_pkg::*;

    logic valid_reg;
    tok_t tok_reg;
    logic last_reg;
    logic sel_reg;      // 1: first token of a two-token record already loaded for output
    logic load;
    logic two;

    assign load = !valid_reg || m_ready;
    assign two  = (head.cnt == 2'd2);
    assign pop  = load && head_valid && (sel_reg || !two);

    assign m_valid = valid_reg;
    assign m_tok   = tok_reg;
    assign m_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end else if (load) begin
            valid_reg <= head_valid;
            if (head_valid) begin
                if (sel_reg) begin
                    tok_reg  <= head.tok1;
                    last_reg <= 1'b1;
                    sel_reg  <= 1'b0;
                end else begin
                    tok_reg  <= head.tok0;
                    last_reg <= !two;
                    sel_reg  <= two;
                end
            end
        end
    end

endmodule

// ----- tb/tb_c_like_token_scanner.sv -----
`timescale 1ns / 100ps

module tb_c_like_token_scanner;

    import ctks_pkg::*;

    localparam int MAX_LEN        = MAX_TOKEN_LEN_DEF;
    localparam int TARGET_BYTES   = 1900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_ROWS       = 25;

    typedef enum logic [2:0] {
        OP_NONE, OP_AMP, OP_BAR, OP_BANG, OP_ASSIGN, OP_GT, OP_LT
    } pend_op_e;

    typedef enum logic [1:0] {
        WORD_NONE, WORD_IDENT, WORD_LIT, WORD_OTHER
    } word_cls_e;

    typedef struct {
        tok_kind_e  kind;
        logic [7:0] len;
        logic       last;
    } token_t;

    typedef struct packed {
        logic [7:0] data;
        logic       le;
        logic       given;  // tokens below are the answer; else use the scanner model
        logic [1:0] n;
        tok_kind_e  k0;
        logic [7:0] l0;
        tok_kind_e  k1;
        logic [7:0] l1;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
        '{"#",   1'b1, 1'b1, 2'd1, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{"#",   1'b0, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{8'hFF, 1'b0, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{"a",   1'b1, 1'b1, 2'd1, KIND_COMMENT, 8'd2, KIND_COMMENT, 8'd0},
        '{8'hFF, 1'b0, 1'b1, 2'd1, KIND_EOF,     8'd1, KIND_COMMENT, 8'd0},
        '{"x",   1'b0, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{"y",   1'b1, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{"9",   1'b0, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{".",   1'b0, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{"z",   1'b0, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{"<",   1'b0, 1'b1, 2'd1, KIND_ERROR,   8'd3, KIND_COMMENT, 8'd0},
        '{"<",   1'b0, 1'b1, 2'd1, KIND_SHL,     8'd2, KIND_COMMENT, 8'd0},
        '{"&",   1'b1, 1'b1, 2'd1, KIND_AMP,     8'd1, KIND_COMMENT, 8'd0},
        '{8'h80, 1'b0, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{8'h00, 1'b0, 1'b1, 2'd1, KIND_ERROR,   8'd1, KIND_COMMENT, 8'd0},
        '{"A",   1'b0, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{">",   1'b0, 1'b1, 2'd1, KIND_IDENT,   8'd1, KIND_COMMENT, 8'd0},
        '{"=",   1'b0, 1'b1, 2'd1, KIND_GE,      8'd2, KIND_COMMENT, 8'd0},
        '{"5",   1'b0, 1'b1, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{8'hFF, 1'b1, 1'b1, 2'd2, KIND_LITERAL, 8'd1, KIND_EOF,     8'd1},
        '{"!",   1'b0, 1'b0, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{"5",   1'b0, 1'b0, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{"=",   1'b0, 1'b0, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{"|",   1'b1, 1'b0, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0},
        '{8'h09, 1'b1, 1'b0, 2'd0, KIND_COMMENT, 8'd0, KIND_COMMENT, 8'd0}
    };

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    // scanner state
    pend_op_e    pend_op       = OP_NONE;
    int unsigned wlen          = 0;
    word_cls_e   wcls          = WORD_NONE;
    bit          wbad          = 1'b0;
    bit          at_line_start = 1'b1;
    bit          in_comment    = 1'b0;
    bit          skipping      = 1'b0;

    token_t      scan_out [2];
    int          scan_n;
    bit          byte_ignored;

    token_t      tokens_due [$];
    token_t      head_tok;
    logic [7:0]  line_q [$];
    int          bytes_scanned = 0;
    int          mismatches    = 0;
    int          quiet_cycles  = 0;
    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;

    c_like_token_scanner uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic tok_kind_e single_kind(pend_op_e p);
        case (p)
            OP_AMP:    return KIND_AMP;
            OP_BAR:    return KIND_BAR;
            OP_BANG:   return KIND_BANG;
            OP_ASSIGN: return KIND_ASSIGN;
            OP_GT:     return KIND_GT;
            default:   return KIND_LT;
        endcase
    endfunction

    task automatic add_tok(input tok_kind_e k, input int unsigned len);
        if (scan_n < 2) begin
            scan_out[scan_n].kind = k;
            scan_out[scan_n].len  = (len > 255) ? 8'd255 : len[7:0];
            scan_out[scan_n].last = 1'b0;
            scan_n++;
        end
    endtask

    task automatic flush_word();
        if (wlen > 0) begin
            if (wcls == WORD_IDENT)
                add_tok(KIND_IDENT, wlen);
            else if (wcls == WORD_LIT && !wbad)
                add_tok(KIND_LITERAL, wlen);
            else
                add_tok(KIND_ERROR, wlen);
        end
        wlen = 0;
        wcls = WORD_NONE;
        wbad = 1'b0;
    endtask

    // tokens caused by one source byte, into scan_out[0 .. scan_n-1]
    task automatic scan_byte(input logic [7:0] b, input logic le);
        tok_kind_e pair_kind;
        tok_kind_e op_kind;
        pend_op_e  new_pend;
        bit        consumed;
        bit        digit;
        scan_n       = 0;
        consumed     = 1'b0;
        byte_ignored = 1'b0;
        digit        = (b >= "0" && b <= "9");
        if (skipping) begin
            byte_ignored = 1'b1;
            if (le) begin
                skipping      = 1'b0;
                at_line_start = 1'b1;
            end
        end else if (in_comment) begin
            if (wlen < MAX_LEN)
                wlen++;
            if (le) begin
                add_tok(KIND_COMMENT, wlen);
                wlen          = 0;
                in_comment    = 1'b0;
                at_line_start = 1'b1;
            end
        end else if (at_line_start && b == "#") begin
            if (le) begin
                add_tok(KIND_COMMENT, 0);
            end else begin
                in_comment    = 1'b1;
                wlen          = 0;
                at_line_start = 1'b0;
            end
        end else begin
            at_line_start = 1'b0;
            if (pend_op != OP_NONE) begin
                pair_kind = KIND_COMMENT;  // no pair formed
                case (pend_op)
                    OP_AMP:    if (b == "&") pair_kind = KIND_AND_AND;
                    OP_BAR:    if (b == "|") pair_kind = KIND_OR_OR;
                    OP_BANG:   if (b == "=") pair_kind = KIND_NE;
                    OP_ASSIGN: if (b == "=") pair_kind = KIND_EQ_EQ;
                    OP_GT: begin
                        if (b == "=") pair_kind = KIND_GE;
                        else if (b == ">") pair_kind = KIND_SHR;
                    end
                    default: begin
                        if (b == "=") pair_kind = KIND_LE;
                        else if (b == "<") pair_kind = KIND_SHL;
                    end
                endcase
                if (pair_kind != KIND_COMMENT) begin
                    add_tok(pair_kind, 2);
                    consumed = 1'b1;
                end else begin
                    add_tok(single_kind(pend_op), 1);
                end
                pend_op = OP_NONE;
            end
            if (!consumed) begin
                if (b == 8'hFF) begin
                    flush_word();
                    add_tok(KIND_EOF, 1);
                    if (!le)
                        skipping = 1'b1;
                end else if (b == " " || b == 8'h0A || b == 8'h09 || b == 8'h00) begin
                    flush_word();
                end else begin
                    new_pend = OP_NONE;
                    op_kind  = KIND_COMMENT;  // not an operator
                    case (b)
                        "&": new_pend = OP_AMP;
                        "|": new_pend = OP_BAR;
                        "!": new_pend = OP_BANG;
                        "=": new_pend = OP_ASSIGN;
                        ">": new_pend = OP_GT;
                        "<": new_pend = OP_LT;
                        ";": op_kind = KIND_SEMI;
                        "{": op_kind = KIND_LBRACE;
                        "}": op_kind = KIND_RBRACE;
                        "(": op_kind = KIND_LPAREN;
                        ")": op_kind = KIND_RPAREN;
                        ",": op_kind = KIND_COMMA;
                        "+": op_kind = KIND_PLUS;
                        "-": op_kind = KIND_MINUS;
                        "*": op_kind = KIND_STAR;
                        "/": op_kind = KIND_SLASH;
                        "~": op_kind = KIND_TILDE;
                        "%": op_kind = KIND_PERCENT;
                        "^": op_kind = KIND_CARET;
                        "?": op_kind = KIND_QUEST;
                        ":": op_kind = KIND_COLON;
                        default: ;
                    endcase
                    if (new_pend != OP_NONE) begin
                        flush_word();
                        pend_op = new_pend;
                    end else if (op_kind != KIND_COMMENT) begin
                        flush_word();
                        add_tok(op_kind, 1);
                    end else begin
                        if (wlen == 0) begin
                            if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))
                                wcls = WORD_IDENT;
                            else if (digit)
                                wcls = WORD_LIT;
                            else
                                wcls = WORD_OTHER;
                            wbad = 1'b0;
                        end else if (!digit && b != ".") begin
                            wbad = 1'b1;
                        end
                        if (wlen < MAX_LEN)
                            wlen++;
                    end
                end
            end
            if (le) begin
                flush_word();
                if (pend_op != OP_NONE) begin
                    add_tok(single_kind(pend_op), 1);
                    pend_op = OP_NONE;
                end
                at_line_start = 1'b1;
            end
        end
        if (scan_n > 0)
            scan_out[scan_n - 1].last = 1'b1;
    endtask

    task automatic push_scanned();
        for (int i = 0; i < scan_n; i++)
            tokens_due.push_back(scan_out[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic le);
        while (tx_idle_on && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= le;
        do @(posedge aclk); while (!s_axis_tready);
        scan_byte(b, le);
        if (!byte_ignored)
            bytes_scanned++;
    endtask

    // long_kind: 0 normal, 1 over-length identifier, 2 over-length comment
    task automatic gen_line(input int long_kind);
        string ops        = ";{}(),+-*/~%^?:&|!=<>";
        string pairs      = "&&||!===>=>><=<<";
        string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        string lit_chars  = "0123456789.";
        int    sel;
        int    idx;
        line_q.delete();
        sel = $urandom_range(99);
        if (long_kind == 2 || (long_kind == 0 && sel < 8)) begin
            line_q.push_back("#");
            repeat (long_kind == 2 ? $urandom_range(256, 300) : $urandom_range(0, 12))
                line_q.push_back(8'($urandom_range(255)));
        end else if (long_kind == 0 && sel < 13) begin
            repeat ($urandom_range(1, 10))
                line_q.push_back(8'($urandom_range(255)));
        end else begin
            if (long_kind == 1) begin
                repeat ($urandom_range(256, 300))
                    line_q.push_back(8'("a" + $urandom_range(25)));
                line_q.push_back(" ");
            end
            repeat ($urandom_range(1, 7)) begin
                sel = $urandom_range(99);
                if (sel < 25) begin
                    line_q.push_back(8'("a" + $urandom_range(25)));
                    repeat ($urandom_range(0, 6))
                        line_q.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
                end else if (sel < 43) begin
                    line_q.push_back(8'("0" + $urandom_range(9)));
                    repeat ($urandom_range(0, 5))
                        line_q.push_back(lit_chars[$urandom_range(lit_chars.len() - 1)]);
                    // malformed number, unless the added character is a digit
                    if (sel >= 38)
                        line_q.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
                end else if (sel < 48) begin
                    case ($urandom_range(3))
                        0: line_q.push_back(8'($urandom_range(8'h80, 8'hFE)));
                        1: line_q.push_back(".");
                        2: line_q.push_back("_");
                        default: line_q.push_back("#");
                    endcase
                    repeat ($urandom_range(0, 3))
                        line_q.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
                end else if (sel < 51) begin
                    line_q.push_back(8'hFF);
                end else if (sel < 55) begin
                    line_q.push_back(8'($urandom_range(255)));
                end else if (sel < 70) begin
                    idx = 2 * $urandom_range(7);
                    line_q.push_back(pairs[idx]);
                    line_q.push_back(pairs[idx + 1]);
                end else begin
                    line_q.push_back(ops[$urandom_range(ops.len() - 1)]);
                end
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: line_q.push_back(" ");
                    6: line_q.push_back(8'h09);
                    7: line_q.push_back(8'h00);
                    8: line_q.push_back(8'h0A);
                    default: ;
                endcase
            end
        end
        if (line_q.size() == 0)
            line_q.push_back(" ");
    endtask

    // result side: random backpressure and token compare
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected token, expected none, got kind %0d len %0d last %0b",
                             $time, m_axis_tdata[5:0], m_axis_tdata[13:6], m_axis_tlast);
                end else begin
                    head_tok = tokens_due.pop_front();
                    if (m_axis_tdata[5:0] !== head_tok.kind) begin
                        mismatches++;
                        $display("%0t: token_kind expected %0d, got %0d",
                                 $time, head_tok.kind, m_axis_tdata[5:0]);
                    end
                    if (m_axis_tdata[13:6] !== head_tok.len) begin
                        mismatches++;
                        $display("%0t: token_length expected %0d, got %0d",
                                 $time, head_tok.len, m_axis_tdata[13:6]);
                    end
                    if (m_axis_tlast !== head_tok.last) begin
                        mismatches++;
                        $display("%0t: last_of_run expected %0b, got %0b",
                                 $time, head_tok.last, m_axis_tlast);
                    end
                end
            end
            m_axis_tready <= rx_idle_on ? ($urandom_range(99) >= 35) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int line_no;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_byte(DIR_ROWS[r].data, DIR_ROWS[r].le);
            if (DIR_ROWS[r].given) begin
                if (DIR_ROWS[r].n >= 1)
                    tokens_due.push_back('{DIR_ROWS[r].k0, DIR_ROWS[r].l0, DIR_ROWS[r].n == 1});
                if (DIR_ROWS[r].n == 2)
                    tokens_due.push_back('{DIR_ROWS[r].k1, DIR_ROWS[r].l1, 1'b1});
            end else begin
                push_scanned();
            end
        end

        // hold the source until the result side has drained
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (tokens_due.size() != 0);

        line_no = 0;
        while (bytes_scanned < TARGET_BYTES) begin
            tx_idle_on = !(line_no >= 60 && line_no < 90);
            rx_idle_on = tx_idle_on;
            if (line_no == 100) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge aclk); while (tokens_due.size() != 0);
            end
            gen_line(line_no == 20 ? 1 : (line_no == 50 ? 2 : 0));
            foreach (line_q[i]) begin
                send_byte(line_q[i], i == line_q.size() - 1);
                push_scanned();
            end
            line_no++;
        end
        s_axis_tvalid <= 1'b0;
        rx_idle_on = 1'b0;

        while (tokens_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && tokens_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
